### src/mmu_pkg.sv
// Shared types, constants and helpers for the matrix multiply unit.
`default_nettype none

package mmu_pkg;

  localparam int MAX_DIM   = 8;
  localparam int IDX_BITS  = 3;
  localparam int DIM_BITS  = 4;
  localparam int ELEM_BITS = 16;
  localparam int PROD_BITS = 35;
  localparam int MUL_BITS  = 2 * ELEM_BITS;
  localparam int ADDR_BITS = 2 * IDX_BITS;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int CFG_BITS  = 2;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  localparam logic [CFG_BITS-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_BITS-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_BITS-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CFG_BITS-1:0] REG_B_COLS = 2'd3;

  localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(MAX_DIM);
  localparam logic [DIM_BITS-1:0] DIM_ONE = DIM_BITS'(1);

  typedef struct packed {
    logic [1:0]                  action;
    logic [IDX_BITS-1:0]         row;
    logic [IDX_BITS-1:0]         col;
    logic signed [ELEM_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [PROD_BITS-1:0] product;
    logic [IDX_BITS-1:0]         out_row;
    logic [IDX_BITS-1:0]         out_col;
    logic                        last;
    logic                        error;
  } out_item_t;

  // Saturate a written dimension into 1..MAX_DIM.
  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] d;
    if (v == '0) begin
      d = DIM_ONE;
    end else if (v > DIM_MAX) begin
      d = DIM_MAX;
    end else begin
      d = v;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### src/mmu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mmu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/matrix_multiply_unit.sv
// Matrix multiply unit: element stores for A and B, multiply-accumulate sequencer.
//
//  channel   signals                          direction  carries
//  in        in_valid, in_ready, in_data      to block   load A / load B / start
//  out       out_valid, out_ready, out_data   from block one product element
//  cfg       cfg_we, cfg_index, cfg_data      to block   a_rows, a_cols, b_rows, b_cols
//
// Loads are taken one per cycle while the block is idle and may follow back to back.
// A start walks the inner index one element pair a cycle through the store read
// port, the multiplier and the accumulator; each product element then waits
// until the output register is free before it is loaded there.
// in_ready is low while a product run is in progress; it rises once the final
// element sits in the output register. Reset clears control only; stores hold
// undefined data until written.
`default_nettype none

module matrix_multiply_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire mmu_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mmu_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [mmu_pkg::CFG_BITS-1:0]    cfg_index,
  input  wire logic [mmu_pkg::DIM_BITS-1:0]    cfg_data
);

  typedef enum logic [2:0] {IDLE, RUN, DRAIN, EMIT, FAULT} state_t;

  state_t state;

  logic [mmu_pkg::DIM_BITS-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [mmu_pkg::IDX_BITS-1:0] i_cnt, j_cnt, k_cnt;

  logic in_xfer, out_free, k_last, j_last, i_last;
  logic we_a, we_b;
  logic [mmu_pkg::ADDR_BITS-1:0] waddr, raddr_a, raddr_b;
  logic [mmu_pkg::ELEM_BITS-1:0] rdata_a, rdata_b;

  logic                                s1_v, s1_first, s1_last;
  logic                                s2_v, s2_first, s2_last;
  logic signed [mmu_pkg::MUL_BITS-1:0]  s2_prod;
  logic signed [mmu_pkg::PROD_BITS-1:0] acc;

  assign in_ready = (state == IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign k_last = ({1'b0, k_cnt} + mmu_pkg::DIM_ONE) == a_cols;
  assign j_last = ({1'b0, j_cnt} + mmu_pkg::DIM_ONE) == b_cols;
  assign i_last = ({1'b0, i_cnt} + mmu_pkg::DIM_ONE) == a_rows;

  assign waddr   = {in_data.row, in_data.col};
  assign we_a    = in_xfer && (in_data.action == mmu_pkg::ACT_LOAD_A);
  assign we_b    = in_xfer && (in_data.action == mmu_pkg::ACT_LOAD_B);
  assign raddr_a = {i_cnt, k_cnt};
  assign raddr_b = {k_cnt, j_cnt};

  mmu_ram #(.WIDTH(mmu_pkg::ELEM_BITS), .DEPTH(mmu_pkg::DEPTH)) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_data.value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mmu_ram #(.WIDTH(mmu_pkg::ELEM_BITS), .DEPTH(mmu_pkg::DEPTH)) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_data.value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Configuration registers, saturated on write.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= mmu_pkg::DIM_MAX;
      a_cols <= mmu_pkg::DIM_MAX;
      b_rows <= mmu_pkg::DIM_MAX;
      b_cols <= mmu_pkg::DIM_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mmu_pkg::REG_A_ROWS: a_rows <= mmu_pkg::clamp_dim(cfg_data);
        mmu_pkg::REG_A_COLS: a_cols <= mmu_pkg::clamp_dim(cfg_data);
        mmu_pkg::REG_B_ROWS: b_rows <= mmu_pkg::clamp_dim(cfg_data);
        mmu_pkg::REG_B_COLS: b_cols <= mmu_pkg::clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  // Read, multiply, accumulate; tags travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= (state == RUN);
      s2_v <= s1_v;
    end
    s1_first <= (k_cnt == '0);
    s1_last  <= k_last;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_prod  <= $signed(rdata_a) * $signed(rdata_b);
    if (s2_v) begin
      acc <= (s2_first ? '0 : acc) + mmu_pkg::PROD_BITS'(s2_prod);
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      i_cnt     <= '0;
      j_cnt     <= '0;
      k_cnt     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_xfer && (in_data.action == mmu_pkg::ACT_START)) begin
            i_cnt <= '0;
            j_cnt <= '0;
            k_cnt <= '0;
            state <= (a_cols != b_rows) ? FAULT : RUN;
          end
        end
        RUN: begin
          if (k_last) begin
            k_cnt <= '0;
            state <= DRAIN;
          end else begin
            k_cnt <= k_cnt + 1'b1;
          end
        end
        DRAIN: begin
          if (s2_v && s2_last) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            out_data.product <= acc;
            out_data.out_row <= i_cnt;
            out_data.out_col <= j_cnt;
            out_data.last    <= i_last && j_last;
            out_data.error   <= 1'b0;
            if (j_last) begin
              j_cnt <= '0;
              i_cnt <= i_cnt + 1'b1;
              state <= i_last ? IDLE : RUN;
            end else begin
              j_cnt <= j_cnt + 1'b1;
              state <= RUN;
            end
          end
        end
        FAULT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            out_data.product <= '0;
            out_data.out_row <= '0;
            out_data.out_col <= '0;
            out_data.last    <= 1'b1;
            out_data.error   <= 1'b1;
            state            <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the matrix multiply unit with queued stimulus and predicted product runs.
`default_nettype none

module tb;
  import mmu_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         N_ITEMS    = 260;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                cfg_we    = 1'b0;
  logic [CFG_BITS-1:0] cfg_index = '0;
  logic [DIM_BITS-1:0] cfg_data  = '0;

  matrix_multiply_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block: element stores and dimensions in use.
  logic signed [ELEM_BITS-1:0] a_mem [DEPTH];
  logic signed [ELEM_BITS-1:0] b_mem [DEPTH];
  logic [DIM_BITS-1:0] rows_a = DIM_BITS'(MAX_DIM);
  logic [DIM_BITS-1:0] cols_a = DIM_BITS'(MAX_DIM);
  logic [DIM_BITS-1:0] rows_b = DIM_BITS'(MAX_DIM);
  logic [DIM_BITS-1:0] cols_b = DIM_BITS'(MAX_DIM);

  // Elements loaded so far, tracked as items are queued.
  bit a_set [DEPTH];
  bit b_set [DEPTH];

  in_item_t  in_q[$];
  out_item_t product_q[$];
  int        n_in_flight = 0;
  int        n_queued    = 0;
  int        n_fail      = 0;
  int        idle_mode   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [DIM_BITS-1:0] sat_dim(input logic [DIM_BITS-1:0] raw);
    if (raw == '0) return DIM_BITS'(1);
    if (raw > DIM_BITS'(MAX_DIM)) return DIM_BITS'(MAX_DIM);
    return raw;
  endfunction

  function automatic string fmt_elem(input out_item_t e);
    return $sformatf("product=%0d row=%0d col=%0d last=%b error=%b",
                     e.product, e.out_row, e.out_col, e.last, e.error);
  endfunction

  task automatic note_fail(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("%s", msg);
  endtask

  // Write an element, or work out the whole product run of a start.
  task automatic store_or_multiply(input in_item_t it);
    out_item_t e;
    longint    acc;
    int        i, j, k;
    case (it.action)
      ACT_LOAD_A: a_mem[{it.row, it.col}] = it.value;
      ACT_LOAD_B: b_mem[{it.row, it.col}] = it.value;
      ACT_START: begin
        if (cols_a != rows_b) begin
          e = '0;
          e.last  = 1'b1;
          e.error = 1'b1;
          product_q.push_back(e);
        end else begin
          for (i = 0; i < rows_a; i++) begin
            for (j = 0; j < cols_b; j++) begin
              acc = 0;
              for (k = 0; k < cols_a; k++)
                acc += longint'(a_mem[ADDR_BITS'(i * MAX_DIM + k)]) *
                       longint'(b_mem[ADDR_BITS'(k * MAX_DIM + j)]);
              e.product = acc[PROD_BITS-1:0];
              e.out_row = IDX_BITS'(i);
              e.out_col = IDX_BITS'(j);
              e.last    = (i == rows_a - 1) && (j == cols_b - 1);
              e.error   = 1'b0;
              product_q.push_back(e);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic bit sender_gap();
    int pct;
    pct = (idle_mode == 0) ? 26 : (idle_mode == 1) ? 58 : 0;
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit receiver_stall();
    int pct;
    pct = (idle_mode == 0) ? 58 : (idle_mode == 1) ? 26 : 0;
    return $urandom_range(99) < pct;
  endfunction

  // Driver: hold the item until its transfer, then advance or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        n_in_flight--;
        store_or_multiply(in_data);
      end
      if (!in_valid || in_ready) begin
        if (in_q.size() != 0 && !sender_gap()) begin
          in_valid <= 1'b1;
          in_data  <= in_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each transfer with the oldest predicted element.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (product_q.size() == 0) begin
          note_fail({"unexpected element: ", fmt_elem(out_data)});
        end else begin
          want = product_q.pop_front();
          if (out_data.product !== want.product || out_data.out_row !== want.out_row ||
              out_data.out_col !== want.out_col || out_data.last !== want.last ||
              out_data.error !== want.error)
            note_fail({"mismatch: expected ", fmt_elem(want), " got ", fmt_elem(out_data)});
        end
      end
      out_ready <= !receiver_stall();
    end
  end

  function automatic logic [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return ELEM_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] act, input int r, input int c,
                            input logic [ELEM_BITS-1:0] v);
    in_item_t it;
    it.action = act;
    it.row    = IDX_BITS'(r);
    it.col    = IDX_BITS'(c);
    it.value  = v;
    if (act == ACT_LOAD_A) a_set[{it.row, it.col}] = 1'b1;
    if (act == ACT_LOAD_B) b_set[{it.row, it.col}] = 1'b1;
    if (act != ACT_UNUSED) n_queued++;
    n_in_flight++;
    in_q.push_back(it);
  endtask

  // Load any element the run would read that was never written, then start.
  task automatic queue_start();
    int i, j, k;
    if (cols_a == rows_b) begin
      for (i = 0; i < rows_a; i++)
        for (k = 0; k < cols_a; k++)
          if (!a_set[ADDR_BITS'(i * MAX_DIM + k)]) queue_item(ACT_LOAD_A, i, k, rand_elem());
      for (k = 0; k < cols_a; k++)
        for (j = 0; j < cols_b; j++)
          if (!b_set[ADDR_BITS'(k * MAX_DIM + j)]) queue_item(ACT_LOAD_B, k, j, rand_elem());
    end
    queue_item(ACT_START, $urandom_range(7), $urandom_range(7), rand_elem());
  endtask

  // Wait until every item is in and every element out, then let the block settle.
  task automatic drain();
    do @(negedge clk); while (n_in_flight != 0 || product_q.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_BITS-1:0] idx, input logic [DIM_BITS-1:0] raw);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= raw;
    case (idx)
      REG_A_ROWS: rows_a = sat_dim(raw);
      REG_A_COLS: cols_a = sat_dim(raw);
      REG_B_ROWS: rows_b = sat_dim(raw);
      REG_B_COLS: cols_b = sat_dim(raw);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_dims(input logic [DIM_BITS-1:0] ar, input logic [DIM_BITS-1:0] ac,
                          input logic [DIM_BITS-1:0] br, input logic [DIM_BITS-1:0] bc);
    @(posedge clk);
    put_reg(REG_A_ROWS, ar);
    put_reg(REG_A_COLS, ac);
    put_reg(REG_B_ROWS, br);
    put_reg(REG_B_COLS, bc);
    cfg_we <= 1'b0;
  endtask

  // Mostly small sizes; now and then zero, the full size or an oversized value.
  function automatic logic [DIM_BITS-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DIM_BITS'($urandom_range(9, 15));
      2:       return DIM_BITS'(MAX_DIM);
      default: return DIM_BITS'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic queue_noise();
    logic [1:0] act;
    act = $urandom_range(1) ? ACT_LOAD_A : ACT_LOAD_B;
    case ($urandom_range(9))
      0:       queue_item(ACT_UNUSED, $urandom_range(7), $urandom_range(7), rand_elem());
      1, 2:    queue_item(act, $urandom_range(7), $urandom_range(7), rand_elem());
      default: begin
        if (act == ACT_LOAD_A)
          queue_item(act, $urandom_range(rows_a - 1), $urandom_range(cols_a - 1), rand_elem());
        else
          queue_item(act, $urandom_range(rows_b - 1), $urandom_range(cols_b - 1), rand_elem());
      end
    endcase
  endtask

  initial begin : stimulus
    logic [DIM_BITS-1:0] ar, ac, br, bc;
    int k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // One by one: most negative squared, mixed extremes, an ignored action.
    set_dims(4'd0, 4'd1, 4'd1, 4'd0);
    queue_item(ACT_LOAD_A, 0, 0, 16'h8000);
    queue_item(ACT_LOAD_B, 0, 0, 16'h8000);
    queue_start();
    queue_item(ACT_LOAD_A, 0, 0, 16'h7FFF);
    queue_start();
    queue_item(ACT_UNUSED, 7, 7, 16'hFFFF);
    queue_start();
    drain();

    // Widest sum: eight most negative products, saturated column count.
    set_dims(4'd1, 4'd15, 4'd8, 4'd1);
    for (k = 0; k < MAX_DIM; k++) begin
      queue_item(ACT_LOAD_A, 0, k, 16'h8000);
      queue_item(ACT_LOAD_B, k, 0, 16'h8000);
    end
    queue_start();
    drain();

    // Inner dimensions disagree.
    set_dims(4'd8, 4'd2, 4'd3, 4'd8);
    queue_start();

    while (n_queued < N_ITEMS) begin
      drain();
      idle_mode = (n_queued < 95) ? 0 : (n_queued < 180) ? 1 : 2;
      ar = pick_dim();
      ac = pick_dim();
      br = ($urandom_range(4) != 0) ? ac : pick_dim();
      bc = pick_dim();
      set_dims(ar, ac, br, bc);
      repeat ($urandom_range(2, 5)) begin
        repeat ($urandom_range(0, 5)) queue_noise();
        queue_start();
      end
    end
    drain();

    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
